@@ hw/rtl/bpa_pkg.sv @@
`default_nettype none

package bpa_pkg;

    localparam int MAX_PAGES     = 4096;
    localparam int MAP_WORD_BITS = 32;
    localparam int MAP_DEPTH     = (MAX_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;

    localparam int WORD_W = MAP_WORD_BITS;
    localparam int BIT_W  = $clog2(MAP_WORD_BITS);
    localparam int ROW_W  = $clog2(MAP_DEPTH);
    localparam int PAGE_W = 12;
    localparam int CNT_W  = 13;
    localparam int ROWC_W = CNT_W - BIT_W;

    localparam logic [1:0] OP_INIT  = 2'd0;
    localparam logic [1:0] OP_ALLOC = 2'd1;
    localparam logic [1:0] OP_FREE  = 2'd2;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_NOFREE = 2'd1;
    localparam logic [1:0] ST_RANGE  = 2'd2;
    localparam logic [1:0] ST_ISFREE = 2'd3;

    localparam logic REG_PAGE_COUNT     = 1'b0;
    localparam logic REG_RESERVED_COUNT = 1'b1;

    localparam logic [CNT_W-1:0] PAGE_COUNT_RST     = CNT_W'(4096);
    localparam logic [CNT_W-1:0] RESERVED_COUNT_RST = CNT_W'(384);

endpackage

`default_nettype wire

@@ hw/rtl/bitmap_page_allocator_unit.sv @@
`default_nettype none

// channel | direction | beat                                   | handshake
// s_      | in        | s_operation, s_page_number             | s_valid / s_ready
// m_      | out       | m_page_index, m_status, m_pages_in_use, | m_valid / m_ready
//         |           | m_free_pages                           |
// cfg_    | in        | cfg_index, cfg_data                    | cfg_valid / cfg_ready
//
// one request at a time; the map is a 128 x 32 memory with one read and one write port
// init: one map row written per cycle, all 128 rows whatever the page count
// allocate: one row read and priority-encoded per cycle, the lowest free page of the first row with
//   one is taken; all rows in range are read when no page is free
// free: read row, test bit, write back; an out-of-range free skips the map
// after reset every map row reads as zero through per-row valid bits, no clearing pass
// a result waits in the output register while m_ready is low; cfg_ready is always high

module bitmap_page_allocator_unit
    import bpa_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [1:0]        s_operation,
    input  wire logic [PAGE_W-1:0] s_page_number,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [PAGE_W-1:0]      m_page_index,
    output logic [1:0]             m_status,
    output logic [CNT_W-1:0]       m_pages_in_use,
    output logic [CNT_W-1:0]       m_free_pages,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic              cfg_index,
    input  wire logic [CNT_W-1:0]  cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_SCAN,
        S_FREE_RD,
        S_FREE_CHK,
        S_PUSH
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    page_count_reg, page_count_next;
    logic [CNT_W-1:0]    reserved_reg, reserved_next;
    logic [CNT_W-1:0]    used_reg, used_next;
    logic [ROWC_W-1:0]   row_reg, row_next;
    logic [ROW_W-1:0]    chk_row_reg, chk_row_next;
    logic                pend_reg, pend_next;
    logic [MAP_DEPTH-1:0] valid_reg, valid_next;
    logic [PAGE_W-1:0]   pn_reg, pn_next;
    logic [PAGE_W-1:0]   res_idx_reg, res_idx_next;
    logic [1:0]          res_status_reg, res_status_next;
    logic                m_valid_reg, m_valid_next;
    logic [PAGE_W-1:0]   m_idx_reg, m_idx_next;
    logic [1:0]          m_status_reg, m_status_next;
    logic [CNT_W-1:0]    m_used_reg, m_used_next;
    logic [CNT_W-1:0]    m_free_reg, m_free_next;

    logic [WORD_W-1:0]   map_mem [MAP_DEPTH];
    logic [WORD_W-1:0]   map_q_reg;
    logic                map_we;
    logic [ROW_W-1:0]    map_wa;
    logic [WORD_W-1:0]   map_wd;
    logic [ROW_W-1:0]    map_ra;

    logic [CNT_W-1:0]    n_pages;
    logic [CNT_W-1:0]    r_pages;
    logic [CNT_W:0]      rows_sum;
    logic [ROWC_W:0]     rows_n;
    logic [WORD_W-1:0]   scan_word;
    logic [WORD_W-1:0]   scan_limit;
    logic [WORD_W-1:0]   free_mask;
    logic                free_any;
    logic [BIT_W-1:0]    free_pos;
    logic [WORD_W-1:0]   init_word;
    logic [WORD_W-1:0]   chk_word;
    logic                chk_bit;

    assign n_pages  = (page_count_reg < CNT_W'(MAX_PAGES)) ? page_count_reg : CNT_W'(MAX_PAGES);
    assign r_pages  = (reserved_reg < CNT_W'(MAX_PAGES)) ? reserved_reg : CNT_W'(MAX_PAGES);
    assign rows_sum = {1'b0, n_pages} + (CNT_W+1)'(MAP_WORD_BITS - 1);
    assign rows_n   = rows_sum[CNT_W:BIT_W];

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid        = m_valid_reg;
    assign m_page_index   = m_idx_reg;
    assign m_status       = m_status_reg;
    assign m_pages_in_use = m_used_reg;
    assign m_free_pages   = m_free_reg;

    // allocate scan: lowest free bit of the row read last cycle, limited to the page count
    always_comb begin
        scan_word = valid_reg[chk_row_reg] ? map_q_reg : '0;
        if ({1'b0, chk_row_reg} < n_pages[CNT_W-1:BIT_W]) begin
            scan_limit = '1;
        end else begin
            scan_limit = (WORD_W'(1) << n_pages[BIT_W-1:0]) - WORD_W'(1);
        end
        free_mask = ~scan_word & scan_limit;
        free_any  = |free_mask;
        free_pos  = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (free_mask[i]) begin
                free_pos = BIT_W'(i);
            end
        end
    end

    // init row contents: full rows below the reserved count, then a partial row, then empty rows
    always_comb begin
        if (row_reg < r_pages[CNT_W-1:BIT_W]) begin
            init_word = '1;
        end else if (row_reg == r_pages[CNT_W-1:BIT_W]) begin
            init_word = (WORD_W'(1) << r_pages[BIT_W-1:0]) - WORD_W'(1);
        end else begin
            init_word = '0;
        end
    end

    assign chk_word = valid_reg[pn_reg[PAGE_W-1:BIT_W]] ? map_q_reg : '0;
    assign chk_bit  = chk_word[pn_reg[BIT_W-1:0]];

    always_comb begin
        state_next      = state_reg;
        page_count_next = page_count_reg;
        reserved_next   = reserved_reg;
        used_next       = used_reg;
        row_next        = row_reg;
        chk_row_next    = chk_row_reg;
        pend_next       = pend_reg;
        valid_next      = valid_reg;
        pn_next         = pn_reg;
        res_idx_next    = res_idx_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg & ~m_ready;
        m_idx_next      = m_idx_reg;
        m_status_next   = m_status_reg;
        m_used_next     = m_used_reg;
        m_free_next     = m_free_reg;
        map_we          = 1'b0;
        map_wa          = '0;
        map_wd          = '0;
        map_ra          = row_reg[ROW_W-1:0];

        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_PAGE_COUNT:     page_count_next = cfg_data;
                REG_RESERVED_COUNT: reserved_next   = cfg_data;
                default:            ;
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    res_idx_next    = '0;
                    res_status_next = ST_DONE;
                    row_next        = '0;
                    pend_next       = 1'b0;
                    pn_next         = s_page_number;
                    case (s_operation)
                        OP_INIT: begin
                            used_next  = r_pages;
                            state_next = S_INIT;
                        end
                        OP_ALLOC: begin
                            state_next = S_SCAN;
                        end
                        OP_FREE: begin
                            if ({1'b0, s_page_number} >= n_pages) begin
                                res_status_next = ST_RANGE;
                                state_next      = S_PUSH;
                            end else begin
                                state_next = S_FREE_RD;
                            end
                        end
                        default: begin
                            state_next = S_PUSH;
                        end
                    endcase
                end
            end
            S_INIT: begin
                map_we   = 1'b1;
                map_wa   = row_reg[ROW_W-1:0];
                map_wd   = init_word;
                row_next = row_reg + ROWC_W'(1);
                if (row_reg[ROW_W-1:0] == ROW_W'(MAP_DEPTH - 1)) begin
                    state_next = S_PUSH;
                end
            end
            S_SCAN: begin
                if (pend_reg && free_any) begin
                    map_we          = 1'b1;
                    map_wa          = chk_row_reg;
                    map_wd          = scan_word | (WORD_W'(1) << free_pos);
                    used_next       = used_reg + CNT_W'(1);
                    res_idx_next    = PAGE_W'({chk_row_reg, free_pos});
                    res_status_next = ST_DONE;
                    pend_next       = 1'b0;
                    state_next      = S_PUSH;
                end else if ({1'b0, row_reg} < rows_n) begin
                    chk_row_next = row_reg[ROW_W-1:0];
                    pend_next    = 1'b1;
                    row_next     = row_reg + ROWC_W'(1);
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        res_status_next = ST_NOFREE;
                        state_next      = S_PUSH;
                    end
                end
            end
            S_FREE_RD: begin
                map_ra     = pn_reg[PAGE_W-1:BIT_W];
                state_next = S_FREE_CHK;
            end
            S_FREE_CHK: begin
                if (chk_bit) begin
                    map_we    = 1'b1;
                    map_wa    = pn_reg[PAGE_W-1:BIT_W];
                    map_wd    = chk_word & ~(WORD_W'(1) << pn_reg[BIT_W-1:0]);
                    used_next = (used_reg != '0) ? used_reg - CNT_W'(1) : used_reg;
                end else begin
                    res_status_next = ST_ISFREE;
                end
                state_next = S_PUSH;
            end
            S_PUSH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_idx_next    = res_idx_reg;
                    m_status_next = res_status_reg;
                    m_used_next   = used_reg;
                    m_free_next   = (n_pages > used_reg) ? n_pages - used_reg : '0;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (map_we) begin
            valid_next[map_wa] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            page_count_reg <= PAGE_COUNT_RST;
            reserved_reg   <= RESERVED_COUNT_RST;
            used_reg       <= '0;
            row_reg        <= '0;
            pend_reg       <= 1'b0;
            valid_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            page_count_reg <= page_count_next;
            reserved_reg   <= reserved_next;
            used_reg       <= used_next;
            row_reg        <= row_next;
            pend_reg       <= pend_next;
            valid_reg      <= valid_next;
            m_valid_reg    <= m_valid_next;
        end
        chk_row_reg    <= chk_row_next;
        pn_reg         <= pn_next;
        res_idx_reg    <= res_idx_next;
        res_status_reg <= res_status_next;
        m_idx_reg      <= m_idx_next;
        m_status_reg   <= m_status_next;
        m_used_reg     <= m_used_next;
        m_free_reg     <= m_free_next;
    end

    // page map memory
    always_ff @(posedge aclk) begin
        if (map_we) begin
            map_mem[map_wa] <= map_wd;
        end
        map_q_reg <= map_mem[map_ra];
    end

    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= CNT_W'(MAX_PAGES))
        else $error("used page count above map size");

    a_idle_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE || state_reg == S_PUSH) |-> !map_we)
        else $error("map written outside a request");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> ({1'b0, row_reg} <= rows_n))
        else $error("scan ran past the last row");

    a_nofree_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_NOFREE) |-> (m_page_index == '0))
        else $error("failed allocate returned a page");

    a_push_after_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FREE_RD) |=> (state_reg == S_FREE_CHK))
        else $error("free request lost its check cycle");

endmodule

`default_nettype wire
